@@ rtl/assert_macros.svh @@
// assertion macros used by multitap_delay_mixer
// depends on nothing; both forms take the clock by name, ASSERT_CLK also the active-low reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// clocked property, disabled while reset is asserted
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked property, also checked during reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

@@ rtl/mtdm_pkg.sv @@
// constants, payload types and microcode word for the multitap delay mixer
// depends on nothing; imported by multitap_delay_mixer
`default_nettype none

package mtdm_pkg;

    // store and delay sizing
    localparam int BUFFER_DEPTH = 524288;
    localparam int MAX_DELAY    = 44000;
    localparam int PTR_W        = $clog2(BUFFER_DEPTH);
    localparam int D_W          = $clog2(MAX_DELAY + 1);

    // sample and control formats
    localparam int SMP_W        = 16;
    localparam int CTL_W        = 13;
    localparam int CTL_FRAC     = 12;
    localparam int CTL_ONE      = 4096;
    localparam int CV_FIVE_VOLT = 10240;
    localparam int TRIG_LEVEL   = 512;

    // taps
    localparam int NUM_TAPS     = 8;
    localparam int TAP_W        = $clog2(NUM_TAPS);
    localparam int TAP_WGT_W    = 7;
    localparam int ACC_W        = 24;

    // configuration register indexes
    localparam int CFG_IDX_W    = 2;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIX    = 2'd2;

    localparam logic [CTL_W-1:0] LENGTH_KNOB_RST = 13'd0;
    localparam logic [CTL_W-1:0] GAIN_KNOB_RST   = 13'd1229;
    localparam logic [CTL_W-1:0] MIX_KNOB_RST    = 13'd2048;

    // sequencer steps
    localparam int PC_W = 4;
    localparam logic [PC_W-1:0] S_IDLE  = 4'd0;
    localparam logic [PC_W-1:0] S_PREP  = 4'd1;
    localparam logic [PC_W-1:0] S_CHECK = 4'd2;
    localparam logic [PC_W-1:0] S_TAP   = 4'd3;
    localparam logic [PC_W-1:0] S_DRAIN = 4'd4;
    localparam logic [PC_W-1:0] S_WET   = 4'd5;
    localparam logic [PC_W-1:0] S_SUM   = 4'd6;
    localparam logic [PC_W-1:0] S_DIV   = 4'd7;
    localparam logic [PC_W-1:0] S_OUT   = 4'd8;

    // branch conditions
    localparam int COND_W = 3;
    localparam logic [COND_W-1:0] C_NEVER     = 3'd0;
    localparam logic [COND_W-1:0] C_ALWAYS    = 3'd1;
    localparam logic [COND_W-1:0] C_NO_REQ    = 3'd2;
    localparam logic [COND_W-1:0] C_D_ZERO    = 3'd3;
    localparam logic [COND_W-1:0] C_TAPS_LEFT = 3'd4;
    localparam logic [COND_W-1:0] C_OUT_BUSY  = 3'd5;

    typedef struct packed {
        logic signed [SMP_W-1:0] sample_in;
        logic signed [SMP_W-1:0] length_cv;
        logic signed [SMP_W-1:0] mix_cv;
        logic signed [SMP_W-1:0] gain_cv;
    } in_item_t;

    typedef struct packed {
        logic signed [SMP_W-1:0] sample_out;
        logic                    trigger;
    } out_item_t;

    typedef struct packed {
        logic              accept;
        logic              prep;
        logic              init_taps;
        logic              tap_rd;
        logic              mul_wet;
        logic              sum;
        logic              div;
        logic              out_ld;
        logic [COND_W-1:0] hold_sel;
        logic [COND_W-1:0] jump_sel;
        logic [PC_W-1:0]   target;
    } ucode_t;

    // tap weights over 80: 1, .7, .4, .2, .1, .05, .025, .0125
    function automatic logic [TAP_WGT_W-1:0] tap_weight(input logic [TAP_W-1:0] k);
        logic [TAP_WGT_W-1:0] w;
        unique case (k)
            3'd0:    w = 7'd80;
            3'd1:    w = 7'd56;
            3'd2:    w = 7'd32;
            3'd3:    w = 7'd16;
            3'd4:    w = 7'd8;
            3'd5:    w = 7'd4;
            3'd6:    w = 7'd2;
            default: w = 7'd1;
        endcase
        return w;
    endfunction

    // control program, one word per step
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        w = '0;
        w.hold_sel = C_NEVER;
        w.jump_sel = C_NEVER;
        w.target   = S_IDLE;
        unique case (pc)
            S_IDLE:
            begin
                w.accept   = 1'b1;
                w.hold_sel = C_NO_REQ;
            end
            S_PREP:  w.prep = 1'b1;
            S_CHECK:
            begin
                w.init_taps = 1'b1;
                w.jump_sel  = C_D_ZERO;
                w.target    = S_WET;
            end
            S_TAP:
            begin
                w.tap_rd   = 1'b1;
                w.jump_sel = C_TAPS_LEFT;
                w.target   = S_TAP;
            end
            S_DRAIN: w.jump_sel = C_NEVER;
            S_WET:   w.mul_wet = 1'b1;
            S_SUM:   w.sum = 1'b1;
            S_DIV:   w.div = 1'b1;
            S_OUT:
            begin
                w.out_ld   = 1'b1;
                w.hold_sel = C_OUT_BUSY;
                w.jump_sel = C_ALWAYS;
                w.target   = S_IDLE;
            end
            default:
            begin
                w.jump_sel = C_ALWAYS;
                w.target   = S_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

@@ rtl/multitap_delay_mixer.sv @@
// multitap delay mixer: microcoded sequencer over a single-port sample store
// depends on mtdm_pkg and assert_macros.svh
//
//   channel   direction  handshake            payload
//   in        request    in_valid / in_stall  in_data   (in_item_t)
//   out       result     out_valid/ out_stall out_data  (out_item_t)
//   cfg       write      cfg_wr_en            cfg_index, cfg_data
//
// steps: accept, store write, check, eight tap reads, drain, three mix steps, output
//   load when the delay is non-zero; a zero delay skips the tap reads and the drain;
//   the tap reads take turns on the one store port
// reset: no clearing pass; the write pointer and a wrapped flag mark which
//   entries hold data, unwritten entries read as zero, requests taken at once
// stalls: the output register holds a result while the next request is taken;
//   only the output step waits if the previous result is still pending
`default_nettype none
`include "assert_macros.svh"

module multitap_delay_mixer (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire mtdm_pkg::in_item_t             in_data,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output mtdm_pkg::out_item_t                 out_data,
    input  wire logic                           cfg_wr_en,
    input  wire logic [mtdm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [mtdm_pkg::CTL_W-1:0]     cfg_data
);
    import mtdm_pkg::*;

    localparam logic [PTR_W:0]      DEPTH_EXT = (PTR_W+1)'(BUFFER_DEPTH);
    localparam logic [D_W-1:0]      MAX_DELAY_V = D_W'(MAX_DELAY);
    localparam logic [CTL_W-1:0]    CTL_ONE_V = CTL_W'(CTL_ONE);
    // x/5 as (x * 26215) >> 17, exact for x below 43690
    localparam logic [14:0]         MUL5_CV = 15'd26215;
    // v/5 as (v * 419431) >> 21, exact for v below 699050
    localparam int                  V_W = 19;
    localparam logic [V_W-1:0]      MUL5_V = 19'd419431;
    localparam int                  NUM_W = 2*CTL_W + 1 + ACC_W;
    localparam int                  DRY_W = CTL_W + 1 + SMP_W;
    localparam int                  DRY80_W = DRY_W + 7;
    localparam int                  T_SHIFT = 28;
    localparam int                  T_W = NUM_W - T_SHIFT;
    localparam logic signed [NUM_W-1:0] ROUND_HALF = NUM_W'(5 * 2**27);
    localparam int                  SAT_SPAN = 5 * 32768;

    // control value: knob plus clamped cv scaled into q1.12, clamped to one
    function automatic logic [CTL_W-1:0] ctl_value(input logic [CTL_W-1:0] knob,
                                                   input logic signed [SMP_W-1:0] cv);
        logic [14:0]    cv2;
        logic [29:0]    prod;
        logic [CTL_W:0] total;
        if (cv < 0)
            cv2 = '0;
        else if (cv > CV_FIVE_VOLT)
            cv2 = 15'(2 * CV_FIVE_VOLT);
        else
            cv2 = {cv[13:0], 1'b0};
        prod  = cv2 * MUL5_CV;
        total = {1'b0, knob} + {1'b0, prod[29:17]};
        return (total > (CTL_W+1)'(CTL_ONE)) ? CTL_ONE_V : total[CTL_W-1:0];
    endfunction

    // sequencer state
    logic [PC_W-1:0]  pc_reg, pc_next;
    ucode_t           cw;
    logic             hold_c, jump_c;

    // configuration
    logic [CTL_W-1:0] length_knob_reg, gain_knob_reg, mix_knob_reg;

    // request operands
    logic signed [SMP_W-1:0] sample_reg;
    logic [CTL_W-1:0]        c_len_reg, c_mix_reg, c_gain_reg;

    // store and pointer
    logic signed [SMP_W-1:0] store_mem [BUFFER_DEPTH];
    logic signed [SMP_W-1:0] rd_data_reg;
    logic [PTR_W-1:0]        wp_reg;
    logic                    wrapped_reg;
    logic [PTR_W:0]          wp_inc_ext;
    logic [PTR_W-1:0]        wp_inc;
    logic [PTR_W-1:0]        mem_addr;

    // tap walk
    logic [D_W-1:0]          d_reg;
    logic [PTR_W-1:0]        off_reg;
    logic [PTR_W:0]          off_sum;
    logic [PTR_W-1:0]        off_adv;
    logic [PTR_W:0]          idx_ext;
    logic [PTR_W-1:0]        tap_idx;
    logic                    tap_ok;
    logic [TAP_W-1:0]        tap_reg;
    logic [TAP_W-1:0]        rd_tap_reg;
    logic                    rd_ok_reg;
    logic                    rd_pend_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [CTL_W+D_W-1:0]    d_prod;

    // mix datapath
    logic signed [DRY_W-1:0]   dry_reg;
    logic [2*CTL_W-1:0]        cg_reg;
    logic signed [DRY80_W-1:0] dry80_reg;
    logic signed [NUM_W-1:0]   wet_reg;
    logic signed [NUM_W-1:0]   num;
    logic signed [T_W-1:0]     t_val;
    logic signed [T_W-1:0]     v_sum;
    logic [V_W-1:0]            v_reg;
    logic                      sat_hi_reg, sat_lo_reg;
    logic [2*V_W-1:0]          q_prod;
    logic signed [SMP_W-1:0]   y_reg;

    // output register
    logic                    out_valid_reg;
    out_item_t               out_data_reg;
    logic                    out_load;

    // microcode fetch and branch conditions
    always_comb
    begin
        cw = ucode_rom(pc_reg);
    end

    always_comb
    begin
        unique case (cw.hold_sel)
            C_ALWAYS:    hold_c = 1'b1;
            C_NO_REQ:    hold_c = !in_valid;
            C_D_ZERO:    hold_c = (d_reg == '0);
            C_TAPS_LEFT: hold_c = (tap_reg != TAP_W'(NUM_TAPS - 1));
            C_OUT_BUSY:  hold_c = out_valid_reg && out_stall;
            default:     hold_c = 1'b0;
        endcase
        unique case (cw.jump_sel)
            C_ALWAYS:    jump_c = 1'b1;
            C_NO_REQ:    jump_c = !in_valid;
            C_D_ZERO:    jump_c = (d_reg == '0);
            C_TAPS_LEFT: jump_c = (tap_reg != TAP_W'(NUM_TAPS - 1));
            C_OUT_BUSY:  jump_c = out_valid_reg && out_stall;
            default:     jump_c = 1'b0;
        endcase
    end

    always_comb
    begin
        priority if (hold_c)
            pc_next = pc_reg;
        else if (jump_c)
            pc_next = cw.target;
        else
            pc_next = pc_reg + 1'b1;
    end

    assign in_stall = !cw.accept;
    assign out_load = cw.out_ld && !hold_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= S_IDLE;
        else
            pc_reg <= pc_next;
    end

    // configuration writes; indexes beyond the list are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_knob_reg <= LENGTH_KNOB_RST;
            gain_knob_reg   <= GAIN_KNOB_RST;
            mix_knob_reg    <= MIX_KNOB_RST;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == REG_LENGTH)
                length_knob_reg <= cfg_data;
            if (cfg_index == REG_GAIN)
                gain_knob_reg <= cfg_data;
            if (cfg_index == REG_MIX)
                mix_knob_reg <= cfg_data;
        end
    end

    // request capture with control values
    always_ff @(posedge clk)
    begin
        if (cw.accept && in_valid)
        begin
            sample_reg <= in_data.sample_in;
            c_len_reg  <= ctl_value(length_knob_reg, in_data.length_cv);
            c_mix_reg  <= ctl_value(mix_knob_reg, in_data.mix_cv);
            c_gain_reg <= ctl_value(gain_knob_reg, in_data.gain_cv);
        end
    end

    // pointer advance and tap address
    always_comb
    begin
        wp_inc_ext = {1'b0, wp_reg} + 1'b1;
        wp_inc     = (wp_inc_ext == DEPTH_EXT) ? '0 : wp_inc_ext[PTR_W-1:0];
        off_sum    = {1'b0, off_reg} + (PTR_W+1)'(d_reg);
        off_adv    = (off_sum >= DEPTH_EXT) ? PTR_W'(off_sum - DEPTH_EXT)
                                            : off_sum[PTR_W-1:0];
        idx_ext    = (wp_reg >= off_reg) ? ({1'b0, wp_reg} - {1'b0, off_reg})
                                         : ({1'b0, wp_reg} + DEPTH_EXT - {1'b0, off_reg});
        tap_idx    = idx_ext[PTR_W-1:0];
        tap_ok     = wrapped_reg || ((tap_idx != '0) && (tap_idx <= wp_reg));
        mem_addr   = cw.prep ? wp_inc : tap_idx;
        d_prod     = c_len_reg * MAX_DELAY_V;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg      <= '0;
            wrapped_reg <= 1'b0;
        end
        else if (cw.prep)
        begin
            wp_reg <= wp_inc;
            if (wp_inc == '0)
                wrapped_reg <= 1'b1;
        end
    end

    // single-port sample store
    always_ff @(posedge clk)
    begin
        if (cw.prep)
            store_mem[mem_addr] <= sample_reg;
        rd_data_reg <= store_mem[mem_addr];
    end

    // tap walk control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg     <= '0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= cw.tap_rd;
            if (cw.init_taps)
                tap_reg <= '0;
            else if (cw.tap_rd)
                tap_reg <= tap_reg + 1'b1;
        end
    end

    // delay length, dry product, gain product, tap offsets and accumulation
    always_ff @(posedge clk)
    begin
        if (cw.prep)
        begin
            d_reg   <= d_prod[D_W+CTL_FRAC-1:CTL_FRAC];
            dry_reg <= $signed({1'b0, CTL_ONE_V - c_mix_reg}) * sample_reg;
            cg_reg  <= c_mix_reg * c_gain_reg;
        end
        if (cw.init_taps)
            off_reg <= PTR_W'(d_reg);
        else if (cw.tap_rd)
            off_reg <= off_adv;
        if (cw.tap_rd)
        begin
            rd_tap_reg <= tap_reg;
            rd_ok_reg  <= tap_ok;
        end
        if (cw.init_taps)
            acc_reg <= '0;
        else if (rd_pend_reg && rd_ok_reg)
            acc_reg <= acc_reg + rd_data_reg * $signed({1'b0, tap_weight(rd_tap_reg)});
    end

    // mix: wet product, rounded sum, saturation and divide by five
    always_comb
    begin
        num    = (NUM_W'(dry80_reg) <<< CTL_FRAC) + wet_reg + ROUND_HALF;
        t_val  = num[NUM_W-1:T_SHIFT];
        v_sum  = t_val + T_W'(SAT_SPAN);
        q_prod = v_reg * MUL5_V;
    end

    always_ff @(posedge clk)
    begin
        if (cw.mul_wet)
        begin
            wet_reg   <= $signed({1'b0, cg_reg}) * acc_reg;
            dry80_reg <= (dry_reg <<< 6) + (dry_reg <<< 4);
        end
        if (cw.sum)
        begin
            sat_hi_reg <= (t_val >= SAT_SPAN);
            sat_lo_reg <= (t_val < -SAT_SPAN);
            v_reg      <= v_sum[V_W-1:0];
        end
        if (cw.div)
        begin
            priority if (sat_hi_reg)
                y_reg <= 16'sh7FFF;
            else if (sat_lo_reg)
                y_reg <= 16'sh8000;
            else
                y_reg <= {~q_prod[21+SMP_W-1], q_prod[21+SMP_W-2:21]};
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg.sample_out <= y_reg;
            out_data_reg.trigger    <= (y_reg > TRIG_LEVEL);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // checks
    `ASSERT_CLK(a_accept_to_prep, clk, rst_n, (in_valid && !in_stall) |=> (pc_reg == S_PREP), "accepted request did not start the program")
    `ASSERT_CLK(a_ptr_only_in_prep, clk, rst_n, (pc_reg != S_PREP) |=> $stable(wp_reg), "write pointer moved outside the write step")
    `ASSERT_CLK(a_read_from_tap, clk, rst_n, rd_pend_reg |-> ($past(pc_reg) == S_TAP), "read data flagged without a tap read")
    `ASSERT_CLK(a_result_from_out, clk, rst_n, $rose(out_valid_reg) |-> ($past(pc_reg) == S_OUT), "result shown outside the output step")

endmodule

`default_nettype wire
